@@ sv/fifo_dedup_recent_list_core_macros.svh @@
// Assertion macros used by the checker file of the recent-ID list.
`ifndef FIFO_DEDUP_RECENT_LIST_CORE_MACROS_SVH
`define FIFO_DEDUP_RECENT_LIST_CORE_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define FDRL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked across reset.
`define FDRL_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/fdrl_pkg.sv @@
// Package with the types, codes and constants of the recent-ID list.
package fdrl_pkg;

    // Field widths fixed by the request and response formats.
    localparam int ID_W    = 32;
    localparam int CNT_W   = 7;
    localparam int CFG_W   = 7;
    localparam int CNT_MAX = (1 << CNT_W) - 1;

    // Default number of entry slots and the capacity after reset.
    localparam int                DEPTH_DEF = 64;
    localparam logic [CFG_W-1:0]  CAP_RESET = CFG_W'(64);

    // Request queue between the front and the back.
    localparam int                  QUEUE_DEPTH = 2;
    localparam int                  QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam logic [QPTR_W:0]     QFILL_FULL  = (QPTR_W + 1)'(QUEUE_DEPTH);

    // Request type codes on the input channel.
    localparam logic REQ_INSERT  = 1'b0;
    localparam logic REQ_READOUT = 1'b1;

    // Result kind codes on the output channel.
    localparam logic KIND_INSERT  = 1'b0;
    localparam logic KIND_READOUT = 1'b1;

    // Operation after classification by the front.
    typedef enum logic {
        OP_INSERT,
        OP_READOUT
    } t_op;

    // Classified request held in the queue.
    typedef struct packed {
        t_op             op;
        logic [ID_W-1:0] id;
    } t_cmd;

    // One response item.
    typedef struct packed {
        logic             result_kind;
        logic             hit;
        logic             evicted;
        logic [ID_W-1:0]  item_id;
        logic [CNT_W-1:0] occupancy;
        logic             is_last;
    } t_result;

    // States of the executing back end.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INSERT,
        ST_RD_ADDR,
        ST_RD_EMIT,
        ST_RD_EMPTY
    } t_state;

endpackage

@@ sv/fdrl_if.sv @@
// Valid/ready channel interfaces for requests and responses of the recent-ID list.
interface fdrl_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] id_in;

    modport source (output valid, output req_type, output id_in, input ready);
    modport sink   (input valid, input req_type, input id_in, output ready);
endinterface

interface fdrl_rsp_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic        hit;
    logic        evicted;
    logic [31:0] item_id;
    logic [6:0]  occupancy;
    logic        is_last;

    modport source (output valid, output result_kind, output hit, output evicted,
                    output item_id, output occupancy, output is_last, input ready);
    modport sink   (input valid, input result_kind, input hit, input evicted,
                    input item_id, input occupancy, input is_last, output ready);
endinterface

@@ sv/fdrl_front.sv @@
// Front end: takes requests, classifies them and queues them for the back end.
module fdrl_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fdrl_req_if.sink      i_req,
    output logic          o_cmd_valid,
    output fdrl_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);
    import fdrl_pkg::*;

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_fill;
    logic              push;
    logic              pop;
    t_cmd              cmd_in;

    // Decode the request type into an operation.
    always_comb begin
        cmd_in.id = i_req.id_in;
        unique case (i_req.req_type)
            REQ_INSERT:  cmd_in.op = OP_INSERT;
            REQ_READOUT: cmd_in.op = OP_READOUT;
            default:     cmd_in.op = OP_INSERT;
        endcase
    end

    // A request is taken whenever the queue has a free slot.
    assign i_req.ready = (r_fill != QFILL_FULL);
    assign push        = i_req.valid && i_req.ready;
    assign pop         = i_cmd_pop && (r_fill != '0);

    assign o_cmd_valid = (r_fill != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

@@ sv/fdrl_back.sv @@
// Back end: match cells, ordered entry memory and the state machine that executes requests.
module fdrl_back #(
    parameter int DEPTH = fdrl_pkg::DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  fdrl_pkg::t_cmd            i_cmd,
    output logic                      o_cmd_pop,
    input  logic                      i_cfg_wr_en,
    input  logic [fdrl_pkg::CFG_W-1:0] i_cfg_wr_data,
    fdrl_rsp_if.source                o_rsp
);
    import fdrl_pkg::*;

    localparam int                PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PTR_W-1:0]  LastSlot  = PTR_W'(DEPTH - 1);
    localparam int                CapMaxInt = (DEPTH < CNT_MAX) ? DEPTH : CNT_MAX;
    localparam logic [CNT_W-1:0]  CapMax    = CNT_W'(CapMaxInt);

    // Match cells, their valid bits, and a copy of the entries for ordered reads.
    logic [ID_W-1:0]  r_cell [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [ID_W-1:0]  r_mem  [DEPTH];
    logic [ID_W-1:0]  r_rd_data;

    t_state           r_state;
    t_state           n_state;
    t_cmd             r_cmd;
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_left;
    logic [CFG_W-1:0] r_capacity;
    logic             r_out_valid;
    t_result          r_out;

    logic [DEPTH-1:0] hit_vec;
    logic             any_hit;
    logic [CNT_W-1:0] eff_cap;
    logic             full;
    logic             out_free;
    logic [PTR_W-1:0] rd_addr;
    logic             emit;
    t_result          res;
    logic             do_write;
    logic             do_evict;
    logic             do_clear;
    logic             load_rd;
    logic             step_rd;

    function automatic logic [PTR_W-1:0] slot_inc(input logic [PTR_W-1:0] p);
        return (p == LastSlot) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] slot_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? LastSlot : p - 1'b1;
    endfunction

    // Compare the pending ID against every held cell at once.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            hit_vec[i] = r_valid[i] && (r_cell[i] == r_cmd.id);
        end
    end
    assign any_hit = |hit_vec;

    // Capacity in use: zero acts as one, and it saturates at the smaller of the slot count and the largest count.
    always_comb begin
        if (r_capacity == '0) begin
            eff_cap = CNT_W'(1);
        end else if (r_capacity > CapMax) begin
            eff_cap = CapMax;
        end else begin
            eff_cap = r_capacity;
        end
    end
    assign full = (r_count >= eff_cap);

    // The output register can take a new response when it is empty or being drained.
    assign out_free = !r_out_valid || o_rsp.ready;

    // The oldest slot is read while an insert is pending, otherwise the readout slot.
    assign rd_addr = ((r_state == ST_IDLE) || (r_state == ST_INSERT)) ? r_head : r_rd_ptr;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        OP_INSERT:  n_state = ST_INSERT;
                        OP_READOUT: n_state = (r_count == '0) ? ST_RD_EMPTY : ST_RD_ADDR;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_INSERT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD_ADDR: begin
                n_state = ST_RD_EMIT;
            end
            ST_RD_EMIT: begin
                if (out_free) begin
                    n_state = (r_left == CNT_W'(1)) ? ST_IDLE : ST_RD_ADDR;
                end
            end
            ST_RD_EMPTY: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State outputs: queue pop, store updates and the response built this cycle.
    always_comb begin
        o_cmd_pop = 1'b0;
        load_rd   = 1'b0;
        step_rd   = 1'b0;
        emit      = 1'b0;
        do_write  = 1'b0;
        do_evict  = 1'b0;
        do_clear  = 1'b0;
        res       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                load_rd   = i_cmd_valid;
            end
            ST_INSERT: begin
                if (out_free) begin
                    emit            = 1'b1;
                    res.result_kind = KIND_INSERT;
                    res.is_last     = 1'b1;
                    if (any_hit) begin
                        res.hit       = 1'b1;
                        res.occupancy = r_count;
                    end else begin
                        do_write      = 1'b1;
                        do_evict      = full;
                        res.evicted   = full;
                        res.item_id   = full ? r_rd_data : '0;
                        res.occupancy = full ? r_count : r_count + 1'b1;
                    end
                end
            end
            ST_RD_ADDR: begin
            end
            ST_RD_EMIT: begin
                if (out_free) begin
                    emit            = 1'b1;
                    res.result_kind = KIND_READOUT;
                    res.item_id     = r_rd_data;
                    res.occupancy   = r_count;
                    res.is_last     = (r_left == CNT_W'(1));
                    do_clear        = (r_left == CNT_W'(1));
                    step_rd         = (r_left != CNT_W'(1));
                end
            end
            ST_RD_EMPTY: begin
                if (out_free) begin
                    emit            = 1'b1;
                    res.result_kind = KIND_READOUT;
                    res.is_last     = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Match cells and the ordered entry memory are written at the newest slot.
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_cell[r_tail] <= r_cmd.id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_mem[r_tail] <= r_cmd.id;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Valid bits: eviction frees the oldest slot, an insert claims the newest, the end of a readout clears all.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (do_clear) begin
            r_valid <= '0;
        end else if (do_evict || do_write) begin
            r_valid <= (r_valid & ~(DEPTH'(do_evict) << r_head)) | (DEPTH'(do_write) << r_tail);
        end
    end

    // Request and readout walk registers.
    always_ff @(posedge i_clk) begin
        if (load_rd) begin
            r_cmd    <= i_cmd;
            r_rd_ptr <= slot_dec(r_tail);
            r_left   <= r_count;
        end else if (step_rd) begin
            r_rd_ptr <= slot_dec(r_rd_ptr);
            r_left   <= r_left - 1'b1;
        end
    end

    // List control state and the state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (do_clear) begin
                r_count <= '0;
                r_head  <= r_tail;
            end else begin
                if (do_evict) begin
                    r_head <= slot_inc(r_head);
                end
                if (do_write) begin
                    r_tail <= slot_inc(r_tail);
                    if (!do_evict) begin
                        r_count <= r_count + 1'b1;
                    end
                end
            end
        end
    end

    // Capacity register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_wr_en) begin
            r_capacity <= i_cfg_wr_data;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result_kind = r_out.result_kind;
    assign o_rsp.hit         = r_out.hit;
    assign o_rsp.evicted     = r_out.evicted;
    assign o_rsp.item_id     = r_out.item_id;
    assign o_rsp.occupancy   = r_out.occupancy;
    assign o_rsp.is_last     = r_out.is_last;

endmodule

@@ sv/fifo_dedup_recent_list_core.sv @@
// Insert: the request enters a two-entry queue; the back end pops it while reading the oldest
// slot, then matches and commits, and the response is registered; the back end takes the next
// request only after committing the current one. Readout: a start step, then an address step
// and an emit step per held entry, newest first; an empty list answers with one bare response.
// Synchronous active-low reset empties the list and queue and sets the capacity to 64 at once.
module fifo_dedup_recent_list_core #(
    parameter int DEPTH = fdrl_pkg::DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    fdrl_req_if.sink                   i_req,
    fdrl_rsp_if.source                 o_rsp,
    input  logic                       i_cfg_wr_en,
    input  logic [fdrl_pkg::CFG_W-1:0] i_cfg_wr_data
);
    import fdrl_pkg::*;

    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    // Request intake and classification.
    fdrl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Request execution against the held list.
    fdrl_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_cmd_pop     (cmd_pop),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_rsp         (o_rsp)
    );

endmodule

@@ sv/fdrl_checker.sv @@
// Checker on the response port of the recent-ID list, with its bind to the top level.
`include "fifo_dedup_recent_list_core_macros.svh"

module fdrl_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       i_ready,
    input logic                       i_kind,
    input logic                       i_hit,
    input logic                       i_evicted,
    input logic [fdrl_pkg::ID_W-1:0]  i_item_id,
    input logic [fdrl_pkg::CNT_W-1:0] i_occupancy,
    input logic                       i_is_last
);
    import fdrl_pkg::*;

    // Reset leaves no response pending.
    `FDRL_ASSERT_NORST(a_reset_quiet, i_clk, !i_rst_n |=> !i_valid, "response valid after reset")

    // Every insert gives exactly one response, so it is always the last one.
    `FDRL_ASSERT(a_insert_last, i_clk, i_rst_n, (i_valid && (i_kind == KIND_INSERT)) |-> i_is_last, "insert response not marked last")

    // A hit changes nothing and names no ID.
    `FDRL_ASSERT(a_hit_clean, i_clk, i_rst_n, (i_valid && i_hit) |-> (!i_evicted && (i_item_id == '0) && (i_kind == KIND_INSERT)), "hit response carries an eviction or an ID")

    // A readout of an empty list is a single bare response.
    `FDRL_ASSERT(a_empty_readout, i_clk, i_rst_n, (i_valid && (i_kind == KIND_READOUT) && (i_occupancy == '0)) |-> (i_is_last && (i_item_id == '0) && !i_hit && !i_evicted), "empty readout malformed")

    // A stalled response holds.
    `FDRL_ASSERT(a_rsp_hold, i_clk, i_rst_n, (i_valid && !i_ready) |=> (i_valid && $stable(i_item_id) && $stable(i_occupancy) && $stable(i_is_last)), "stalled response changed")

endmodule

bind fifo_dedup_recent_list_core fdrl_checker u_fdrl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_rsp.valid),
    .i_ready     (o_rsp.ready),
    .i_kind      (o_rsp.result_kind),
    .i_hit       (o_rsp.hit),
    .i_evicted   (o_rsp.evicted),
    .i_item_id   (o_rsp.item_id),
    .i_occupancy (o_rsp.occupancy),
    .i_is_last   (o_rsp.is_last)
);
